// ===== rtl/valid_2d_image_correlation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the image correlation block
// Implication checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef VALID_2D_IMAGE_CORRELATION_ASSERT_SVH
`define VALID_2D_IMAGE_CORRELATION_ASSERT_SVH
`ifndef ASSERT_OFF
`define VIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VIC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/vic_pkg.sv =====
// ----------------------------------------------------------------------------
// vic_pkg
// Shared types and constants of the valid-mode image correlation block.
// ----------------------------------------------------------------------------
`default_nettype none
package vic_pkg;
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_KERNEL = 7;
    localparam int ROW_LIMIT      = 4096;
    localparam int PIX_W          = 16;
    localparam int PROD_W         = 32;
    localparam int SUM_W          = 48;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_W      = 40;
    localparam int OUT_DATA_W     = 72;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_JOB  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         tap_row;
        logic [2:0]         tap_col;
        logic signed [15:0] coef;
        logic [11:0]        row;
        logic [9:0]         col;
        logic               last;
    } ctl_t;
endpackage
`default_nettype wire

// ===== rtl/valid_2d_image_correlation.sv =====
// ----------------------------------------------------------------------------
// valid_2d_image_correlation
// Valid-mode 2D correlation of a raster image with an odd kernel up to
// MAX_KERNEL square, with line stores and a pipelined multiply-add tree.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_*      in         tuser: cmd; tdata: tap_row, tap_col, coefficient, pixel
// m_*      out        tuser: error; tlast: last; tdata: sum, out_row, out_col
// cfg_*    in         register index and write data, no read-back
//
// One item is taken every cycle while the queue has room; a result passes the
// queue, then the product, row-sum and total registers. The line store banks
// are read once per pixel; the four-entry queue before the tree absorbs stalls.
// Reset clears the raster position; the kernel and line stores hold no reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "valid_2d_image_correlation_assert.svh"
module valid_2d_image_correlation #(
    parameter int MAX_COLS   = vic_pkg::DEF_MAX_COLS,
    parameter int MAX_KERNEL = vic_pkg::DEF_MAX_KERNEL
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tap_row[2:0], tap_col[5:3], coefficient[21:6], pixel[37:22]
    input  logic [vic_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sum[47:0], out_row[59:48], out_col[69:60]
    output logic [vic_pkg::OUT_DATA_W-1:0]    m_tdata,
    // error
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [12:0]                       cfg_data
);
    import vic_pkg::*;

    localparam int NPIX = MAX_KERNEL * MAX_KERNEL;
    localparam int QW   = $bits(ctl_t) + NPIX * 16;

    localparam logic [1:0] REG_FRAME_ROWS = 2'd0;
    localparam logic [1:0] REG_FRAME_COLS = 2'd1;
    localparam logic [1:0] REG_HALF_ROWS  = 2'd2;
    localparam logic [1:0] REG_HALF_COLS  = 2'd3;

    logic [12:0]           frame_rows_reg;
    logic [10:0]           frame_cols_reg;
    logic [1:0]            half_rows_reg, half_cols_reg;
    logic                  push, pop, head_valid;
    ctl_t                  push_ctl, head_ctl;
    logic [NPIX*16-1:0]    push_pix, head_pix;
    logic [QW-1:0]         head_data;
    logic [QCNT_W-1:0]     q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= 13'd16;
            frame_cols_reg <= 11'd16;
            half_rows_reg  <= 2'd1;
            half_cols_reg  <= 2'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                REG_FRAME_COLS: frame_cols_reg <= cfg_data[10:0];
                REG_HALF_ROWS:  half_rows_reg  <= cfg_data[1:0];
                REG_HALF_COLS:  half_cols_reg  <= cfg_data[1:0];
                default:        frame_rows_reg <= frame_rows_reg;
            endcase
        end
    end

    vic_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .frame_rows       (frame_rows_reg),
        .frame_cols       (frame_cols_reg),
        .kernel_half_rows (half_rows_reg),
        .kernel_half_cols (half_cols_reg),
        .q_count          (q_count),
        .push             (push),
        .push_ctl         (push_ctl),
        .push_pix         (push_pix)
    );

    vic_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_ctl, push_pix}),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (q_count)
    );

    assign head_ctl = head_data[QW-1:NPIX*16];
    assign head_pix = head_data[NPIX*16-1:0];

    vic_back #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ctl   (head_ctl),
        .head_pix   (head_pix),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    `VIC_ASSERT_IMP(a_err_clean, clk, rst_n, m_tvalid && m_tuser, (m_tdata == '0) && !m_tlast)
    `VIC_ASSERT_IMP(a_stall_backlog, clk, rst_n, !s_tready, q_count != '0)
    `VIC_ASSERT_NEXT(a_push_bound, clk, rst_n, push, q_count != '0)
endmodule
`default_nettype wire

// ===== rtl/vic_queue.sv =====
// ----------------------------------------------------------------------------
// vic_queue
// Small register queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none
module vic_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic                       head_valid,
    output logic [WIDTH-1:0]           head_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]           mem_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [$clog2(DEPTH+1)-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
endmodule
`default_nettype wire

// ===== rtl/vic_front.sv =====
// ----------------------------------------------------------------------------
// vic_front
// Takes items, tracks the raster position, keeps the line stores and the
// pixel window, and queues loads, window jobs and error results.
// ----------------------------------------------------------------------------
`default_nettype none
module vic_front #(
    parameter int MAX_COLS   = vic_pkg::DEF_MAX_COLS,
    parameter int MAX_KERNEL = vic_pkg::DEF_MAX_KERNEL
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [vic_pkg::IN_DATA_W-1:0]          s_tdata,
    input  logic                                   s_tuser,
    input  logic [12:0]                            frame_rows,
    input  logic [10:0]                            frame_cols,
    input  logic [1:0]                             kernel_half_rows,
    input  logic [1:0]                             kernel_half_cols,
    input  logic [vic_pkg::QCNT_W-1:0]             q_count,
    output logic                                   push,
    output vic_pkg::ctl_t                          push_ctl,
    output logic [MAX_KERNEL*MAX_KERNEL*16-1:0]    push_pix
);
    import vic_pkg::*;

    localparam int LROWS  = MAX_KERNEL - 1;
    localparam int SLOT_W = (LROWS > 1) ? $clog2(LROWS) : 1;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int IDX_W  = $clog2(MAX_KERNEL);

    logic [11:0]        row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               acc, is_pix, err, emit, take_pix;
    logic [2:0]         kh, kw;
    logic signed [15:0] px_in;

    logic signed [15:0] rd_reg [LROWS];
    logic signed [15:0] win_reg [MAX_KERNEL][MAX_KERNEL];
    logic signed [15:0] win_next [MAX_KERNEL][MAX_KERNEL];

    logic               s1_valid_reg;
    logic               s1_pix_reg, s1_err_reg, s1_emit_reg, s1_last_reg;
    logic signed [15:0] s1_px_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [11:0]        s1_row_reg;
    logic [9:0]         s1_col_reg;
    logic [2:0]         s1_tap_row_reg, s1_tap_col_reg;
    logic signed [15:0] s1_coef_reg;

    assign kh     = {kernel_half_rows, 1'b1};
    assign kw     = {kernel_half_cols, 1'b1};
    assign is_pix = s_tuser;
    assign px_in  = s_tdata[37:22];

    assign s_tready = (32'(q_count) + 32'(s1_valid_reg)) < QUEUE_DEPTH;
    assign acc      = s_tvalid && s_tready;

    assign err = (32'(kh) >= 32'(frame_rows)) || (32'(kw) >= 32'(frame_cols)) ||
                 (32'(frame_cols) > MAX_COLS) || (32'(frame_rows) > ROW_LIMIT) ||
                 (32'(kh) > MAX_KERNEL) || (32'(kw) > MAX_KERNEL);
    assign take_pix = acc && is_pix && !err;
    assign emit     = (32'(row_reg) + 1 >= 32'(kh)) && (32'(col_reg) + 1 >= 32'(kw));

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        slot_next = slot_reg;
        if (take_pix)
        begin
            if (32'(col_reg) + 1 >= 32'(frame_cols))
            begin
                col_next = '0;
                if (32'(row_reg) + 1 >= 32'(frame_rows))
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    slot_next = (32'(slot_reg) == LROWS - 1) ? '0 : slot_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            slot_reg     <= slot_next;
            s1_valid_reg <= acc;
        end
    end

    for (genvar b = 0; b < LROWS; b++)
    begin : g_bank
        logic signed [15:0] line_mem [MAX_COLS];

        always_ff @(posedge clk)
        begin
            if (take_pix && (32'(slot_reg) == b))
            begin
                line_mem[col_reg] <= px_in;
            end
            if (take_pix)
            begin
                rd_reg[b] <= line_mem[col_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pix_reg     <= is_pix;
            s1_err_reg     <= err;
            s1_emit_reg    <= emit;
            s1_px_reg      <= px_in;
            s1_slot_reg    <= slot_reg;
            s1_row_reg     <= 12'(32'(row_reg) - 32'(kh) + 1);
            s1_col_reg     <= 10'(32'(col_reg) - 32'(kw) + 1);
            s1_last_reg    <= (32'(row_reg) + 1 == 32'(frame_rows)) &&
                              (32'(col_reg) + 1 == 32'(frame_cols));
            s1_tap_row_reg <= s_tdata[2:0];
            s1_tap_col_reg <= s_tdata[5:3];
            s1_coef_reg    <= s_tdata[21:6];
        end
        if (s1_valid_reg && s1_pix_reg && !s1_err_reg)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        int t;
        for (int a = 0; a < MAX_KERNEL; a++)
        begin
            for (int j = 0; j < MAX_KERNEL - 1; j++)
            begin
                win_next[a][j] = win_reg[a][j+1];
            end
        end
        win_next[0][MAX_KERNEL-1] = s1_px_reg;
        for (int a = 1; a < MAX_KERNEL; a++)
        begin
            t = 32'(s1_slot_reg) - ((a == LROWS) ? 0 : a);
            if (t < 0)
            begin
                t = t + LROWS;
            end
            win_next[a][MAX_KERNEL-1] = rd_reg[SLOT_W'(t)];
        end
    end

    always_comb
    begin
        int ra;
        int ca;
        for (int dx = 0; dx < MAX_KERNEL; dx++)
        begin
            for (int dy = 0; dy < MAX_KERNEL; dy++)
            begin
                ra = 32'(kh) - 1 - dx;
                ca = MAX_KERNEL - 32'(kw) + dy;
                push_pix[(dx*MAX_KERNEL+dy)*16 +: 16] = '0;
                if (ra >= 0 && ca >= 0 && ca < MAX_KERNEL && dy < 32'(kw))
                begin
                    push_pix[(dx*MAX_KERNEL+dy)*16 +: 16] =
                        win_next[IDX_W'(ra)][IDX_W'(ca)];
                end
            end
        end
    end

    assign push = s1_valid_reg && (!s1_pix_reg || s1_err_reg || s1_emit_reg);

    always_comb
    begin
        push_ctl         = '0;
        push_ctl.tap_row = s1_tap_row_reg;
        push_ctl.tap_col = s1_tap_col_reg;
        push_ctl.coef    = s1_coef_reg;
        if (!s1_pix_reg)
        begin
            push_ctl.kind = KIND_LOAD;
        end
        else if (s1_err_reg)
        begin
            push_ctl.kind = KIND_ERR;
        end
        else
        begin
            push_ctl.kind = KIND_JOB;
            push_ctl.row  = s1_row_reg;
            push_ctl.col  = s1_col_reg;
            push_ctl.last = s1_last_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/vic_back.sv =====
// ----------------------------------------------------------------------------
// vic_back
// Holds the kernel and runs the pipelined multiply and adder tree.
// ----------------------------------------------------------------------------
`default_nettype none
module vic_back #(
    parameter int MAX_KERNEL = vic_pkg::DEF_MAX_KERNEL
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  vic_pkg::ctl_t                       head_ctl,
    input  logic [MAX_KERNEL*MAX_KERNEL*16-1:0] head_pix,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vic_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import vic_pkg::*;

    localparam int NPIX   = MAX_KERNEL * MAX_KERNEL;
    localparam int KIDX_W = $clog2(NPIX);

    logic               adv;
    logic signed [15:0] kern_reg [NPIX];
    logic signed [PROD_W-1:0] prod_reg [NPIX];
    logic signed [SUM_W-1:0]  rsum_reg [MAX_KERNEL];
    logic signed [SUM_W-1:0]  rsum_next [MAX_KERNEL];
    logic signed [SUM_W-1:0]  sum_next, sum_reg;
    logic               v1_reg, v2_reg, v3_reg;
    ctl_t               c1_reg, c2_reg, c3_reg;

    assign adv = !v3_reg || m_tready;
    assign pop = head_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pop && (head_ctl.kind != KIND_LOAD);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (head_ctl.kind == KIND_LOAD) && (32'(head_ctl.tap_row) < MAX_KERNEL) &&
            (32'(head_ctl.tap_col) < MAX_KERNEL))
        begin
            kern_reg[KIDX_W'(32'(head_ctl.tap_row) * MAX_KERNEL + 32'(head_ctl.tap_col))]
                <= head_ctl.coef;
        end
        if (adv)
        begin
            c1_reg <= head_ctl;
            for (int i = 0; i < NPIX; i++)
            begin
                prod_reg[i] <= (head_ctl.kind == KIND_ERR) ? '0 :
                    PROD_W'($signed(head_pix[i*16 +: 16]) * kern_reg[i]);
            end
            c2_reg   <= c1_reg;
            rsum_reg <= rsum_next;
            c3_reg   <= c2_reg;
            sum_reg  <= sum_next;
        end
    end

    always_comb
    begin
        for (int a = 0; a < MAX_KERNEL; a++)
        begin
            rsum_next[a] = '0;
            for (int j = 0; j < MAX_KERNEL; j++)
            begin
                rsum_next[a] = rsum_next[a] + SUM_W'(prod_reg[a*MAX_KERNEL+j]);
            end
        end
        sum_next = '0;
        for (int a = 0; a < MAX_KERNEL; a++)
        begin
            sum_next = sum_next + rsum_reg[a];
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {2'b00, c3_reg.col, c3_reg.row, sum_reg};
    assign m_tuser  = (c3_reg.kind == KIND_ERR);
    assign m_tlast  = c3_reg.last;
endmodule
`default_nettype wire

// ===== dv/valid_2d_image_correlation_test.sv =====
// ----------------------------------------------------------------------------
// Image correlation block test
// Loads kernels and streams whole frames through the block under many frame
// and kernel sizes, including unprocessable ones, with random bursts on the
// input and random stalls on the output. Every result is checked against a
// predicted window sum, position, frame end mark and error flag.
// ----------------------------------------------------------------------------
`default_nettype none
module valid_2d_image_correlation_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vic_pkg::*;

    localparam int CMD_LOAD  = 0;
    localparam int CMD_PIXEL = 1;
    localparam int REG_ROWS  = 0;
    localparam int REG_COLS  = 1;
    localparam int REG_HROWS = 2;
    localparam int REG_HCOLS = 3;
    localparam int KSIZE     = 7;
    localparam int NCOLS     = 1024;
    localparam int LROWS     = KSIZE - 1;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                  cmd;
        logic [IN_DATA_W-1:0]  data;
    } beat_t;

    typedef struct packed {
        logic [47:0] sum;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
        logic        err;
    } window_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [12:0] cfg_data;

    beat_t pending_beats[$];
    window_result_t expected_sums[$];

    int rows_reg;
    int cols_reg;
    int hrows_reg;
    int hcols_reg;
    logic signed [15:0] kernel_taps[KSIZE*KSIZE];
    logic signed [15:0] line_mem[LROWS][NCOLS];
    logic signed [15:0] win[KSIZE][KSIZE];
    int pos_row;
    int pos_col;

    int burst_left;
    int gap_left;
    int stall_mode;
    int mismatches;
    int results_seen;
    int errors_seen;
    int pixels_sent;
    int phases_run;
    longint cycles;

    valid_2d_image_correlation dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void correlate_item(input logic cmd, input logic [IN_DATA_W-1:0] d);
        int kh;
        int kw;
        int r;
        int c;
        int slot;
        longint acc;
        logic signed [15:0] px;
        window_result_t res;
        kh = 2 * hrows_reg + 1;
        kw = 2 * hcols_reg + 1;
        r = pos_row;
        c = pos_col;
        res = '0;
        if (cmd == CMD_LOAD)
        begin
            if (d[2:0] < KSIZE && d[5:3] < KSIZE)
                kernel_taps[d[2:0] * KSIZE + d[5:3]] = d[21:6];
            return;
        end
        if (kh >= rows_reg || kw >= cols_reg || cols_reg > NCOLS || rows_reg > ROW_LIMIT)
        begin
            res.err = 1'b1;
            expected_sums.push_back(res);
            return;
        end
        px = d[37:22];
        for (int a = 0; a < KSIZE; a++)
            for (int j = 0; j < KSIZE - 1; j++)
                win[a][j] = win[a][j+1];
        win[0][KSIZE-1] = px;
        for (int a = 1; a < KSIZE; a++)
        begin
            slot = (r % LROWS + LROWS - (a % LROWS)) % LROWS;
            win[a][KSIZE-1] = line_mem[slot][c];
        end
        line_mem[r % LROWS][c] = px;
        pos_col = c + 1;
        if (pos_col >= cols_reg)
        begin
            pos_col = 0;
            pos_row = r + 1;
            if (pos_row >= rows_reg)
                pos_row = 0;
        end
        if (r + 1 < kh || c + 1 < kw)
            return;
        acc = 0;
        for (int dx = 0; dx < kh; dx++)
            for (int dy = 0; dy < kw; dy++)
                acc += longint'(win[kh-1-dx][KSIZE-kw+dy]) * longint'(kernel_taps[dx*KSIZE+dy]);
        res.sum = acc[47:0];
        res.row = 12'(r - (kh - 1));
        res.col = 10'(c - (kw - 1));
        res.last = (r + 1 == rows_reg && c + 1 == cols_reg);
        expected_sums.push_back(res);
    endfunction

    task automatic send_item(input logic cmd, input logic [2:0] tr, input logic [2:0] tc,
                             input logic [15:0] coef, input logic [15:0] px);
        beat_t b;
        b.cmd = cmd;
        b.data = {2'b00, px, coef, tc, tr};
        @(negedge clk);
        correlate_item(b.cmd, b.data);
        pending_beats.push_back(b);
        if (cmd == CMD_PIXEL)
            pixels_sent++;
    endtask

    task automatic drain();
        wait (pending_beats.size() == 0 && !s_tvalid);
        wait (expected_sums.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 13'(value);
        case (idx)
            REG_ROWS:  rows_reg = value & 13'h1fff;
            REG_COLS:  cols_reg = value & 11'h7ff;
            REG_HROWS: hrows_reg = value & 3;
            default:   hcols_reg = value & 3;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int nr, input int nc, input int hr, input int hc);
        drain();
        write_reg(REG_ROWS, nr);
        write_reg(REG_COLS, nc);
        write_reg(REG_HROWS, hr);
        write_reg(REG_HCOLS, hc);
        stall_mode = $urandom_range(0, 3);
        phases_run++;
    endtask

    // Flavor 0 is random, 1 is the largest weight and 2 the most negative weight;
    // the pixels come from send_frame, whose flavor 1 is most negative.
    task automatic load_kernel(input int flavor);
        logic [15:0] w;
        for (int i = 0; i < KSIZE; i++)
            for (int j = 0; j < KSIZE; j++)
            begin
                w = (flavor == 1) ? 16'h7fff : (flavor == 2) ? 16'h8000 : 16'($urandom);
                send_item(CMD_LOAD, 3'(i), 3'(j), w, 16'($urandom));
            end
        send_item(CMD_LOAD, 3'd7, 3'($urandom), 16'($urandom), 16'($urandom));
        send_item(CMD_LOAD, 3'($urandom), 3'd7, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_frame(input int flavor, input bit noisy);
        logic [15:0] px;
        for (int n = 0; n < rows_reg * cols_reg; n++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(CMD_LOAD, 3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom));
            px = (flavor == 0) ? 16'($urandom) : 16'h8000;
            send_item(CMD_PIXEL, 3'($urandom), 3'($urandom), 16'($urandom), px);
        end
    endtask

    task automatic send_rejected(input int count);
        for (int n = 0; n < count; n++)
            send_item(CMD_PIXEL, 3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid)
                void'(pending_beats.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_beats[0].data;
                s_tuser <= pending_beats[0].cmd;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 300)
                                                          : $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 6);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t got;
        window_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.sum = m_tdata[47:0];
                got.row = m_tdata[59:48];
                got.col = m_tdata[69:60];
                got.last = m_tlast;
                got.err = m_tuser;
                results_seen++;
                if (got.err)
                    errors_seen++;
                if (expected_sums.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: sum %h row %0d col %0d last %b error %b",
                                 got.sum, got.row, got.col, got.last, got.err);
                    mismatches++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected sum %h row %0d col %0d last %b",
                                     want.sum, want.row, want.col, want.last,
                                     " error %b, got sum %h row %0d col %0d last %b",
                                     want.err, got.sum, got.row, got.col, got.last,
                                     " error %b", got.err);
                        mismatches++;
                    end
                end
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 9) < 7;
                2: m_tready <= $urandom_range(0, 15) != 0;
                default: m_tready <= (cycles % 64) < 40;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("valid_2d_image_correlation_test: errors");
            $finish;
        end
    end

    initial
    begin
        int kh;
        int kw;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stall_mode = 0;
        mismatches = 0;
        results_seen = 0;
        errors_seen = 0;
        pixels_sent = 0;
        phases_run = 0;
        cycles = 0;
        rows_reg = 16;
        cols_reg = 16;
        hrows_reg = 1;
        hcols_reg = 1;
        pos_row = 0;
        pos_col = 0;
        foreach (kernel_taps[i])
            kernel_taps[i] = '0;
        foreach (win[i, j])
            win[i][j] = '0;
        foreach (line_mem[i, j])
            line_mem[i][j] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        load_kernel(1);
        send_frame(1, 0);
        load_kernel(2);
        send_frame(1, 0);
        configure(8, 8, 3, 3);
        load_kernel(0);
        send_frame(0, 0);
        configure(3, 3, 0, 0);
        send_frame(0, 1);
        configure(2, 64, 0, 0);
        send_frame(0, 0);
        configure(64, 2, 0, 0);
        send_frame(0, 0);
        configure(1, 1, 0, 0);
        send_rejected(4);
        configure(7, 16, 3, 0);
        send_rejected(3);
        configure(16, 5, 0, 2);
        send_rejected(3);
        configure(8191, 16, 1, 1);
        send_rejected(3);
        configure(16, 2047, 1, 1);
        send_rejected(3);

        while (pixels_sent < 1200)
        begin
            kh = $urandom_range(0, 3);
            kw = $urandom_range(0, 3);
            configure($urandom_range(2 * kh + 2, 14), $urandom_range(2 * kw + 2, 20), kh, kw);
            if ($urandom_range(0, 2) == 0)
                load_kernel(0);
            repeat ($urandom_range(1, 2))
                send_frame(0, 1);
            if ($urandom_range(0, 9) == 0)
            begin
                configure($urandom_range(1, 3), $urandom_range(1, 3), 1, 1);
                send_rejected($urandom_range(1, 5));
            end
        end

        drain();
        repeat (50) @(posedge clk);
        $display("ran %0d configurations with %0d pixels in %0d cycles", phases_run,
                 pixels_sent, cycles);
        $display("checked %0d results, %0d of them error results", results_seen, errors_seen);
        if (mismatches == 0 && expected_sums.size() == 0)
            $display("valid_2d_image_correlation_test: clean");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     expected_sums.size());
            $display("valid_2d_image_correlation_test: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
